// ----- sv/wtr_pkg.sv -----
package wtr_pkg;

  localparam int MAX_WIDTH  = 512;
  localparam int MAX_HEIGHT = 256;

  localparam int COL_W  = $clog2(MAX_WIDTH);   // column index
  localparam int WID_W  = COL_W + 1;           // width value, up to MAX_WIDTH
  localparam int ROW_W  = $clog2(MAX_HEIGHT);  // row index
  localparam int SMP_W  = 32;
  localparam int CNT_W  = 16;                  // sample index / sample_count
  localparam int CLR_W  = 32;
  localparam int PW_REG_W = 10;
  localparam int PH_REG_W = 9;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_FULL_SCALE   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_COUNT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PLOT_WIDTH   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_PLOT_HEIGHT  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_TRACE_COLOR  = 3'd4;

  // effective configuration seen by front and back
  typedef struct packed {
    logic [SMP_W-1:0] full_scale;
    logic [CNT_W-1:0] sample_count;
    logic [WID_W-1:0] width;       // clamped to MAX_WIDTH
    logic [ROW_W-1:0] height_m1;   // clamped height minus one
    logic [CLR_W-1:0] color;
  } cfg_t;

  // picked point handed from front to back
  typedef struct packed {
    logic [SMP_W-1:0] diff;        // full_scale - clamped sample
    logic [COL_W-1:0] column;
    logic             first;
  } point_t;

endpackage

// ----- sv/wtr_intf.sv -----
interface wtr_in_if;
  logic                      valid;
  logic                      ready;
  logic [wtr_pkg::SMP_W-1:0] sample;
  logic                      trace_start;
  modport source (output valid, sample, trace_start, input ready);
  modport sink   (input valid, sample, trace_start, output ready);
endinterface

interface wtr_out_if;
  logic                      valid;
  logic                      ready;
  logic [wtr_pkg::COL_W-1:0] column;
  logic [wtr_pkg::ROW_W-1:0] span_top;
  logic [wtr_pkg::ROW_W-1:0] span_bottom;
  logic [wtr_pkg::CLR_W-1:0] pixel_color;
  logic                      last_of_item;
  modport source (output valid, column, span_top, span_bottom, pixel_color, last_of_item,
                  input ready);
  modport sink   (input valid, column, span_top, span_bottom, pixel_color, last_of_item,
                  output ready);
endinterface

// ----- sv/wtr_fifo.sv -----
module wtr_fifo (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  wtr_pkg::point_t push_data,
  output logic            full,
  input  logic            pop,
  output wtr_pkg::point_t pop_data,
  output logic            empty
);
  import wtr_pkg::*;

  point_t     mem_r [2];
  logic       wr_ptr_r, rd_ptr_r;
  logic [1:0] count_r;

  assign full     = (count_r == 2'd2);
  assign empty    = (count_r == 2'd0);
  assign pop_data = mem_r[rd_ptr_r];

  // storage
  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= push_data;
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (push) wr_ptr_r <= ~wr_ptr_r;
      if (pop)  rd_ptr_r <= ~rd_ptr_r;
      count_r <= count_r + {1'b0, push} - {1'b0, pop};
    end
  end
endmodule

// ----- sv/wtr_front.sv -----
module wtr_front (
  input  logic            clk,
  input  logic            rst_n,
  input  wtr_pkg::cfg_t   cfg,
  wtr_in_if.sink          in_if,
  output logic            push,
  output wtr_pkg::point_t push_data,
  input  logic            q_full
);
  import wtr_pkg::*;

  localparam logic [1:0] F_IDLE = 2'd0;
  localparam logic [1:0] F_MUL  = 2'd1;
  localparam logic [1:0] F_DIV  = 2'd2;

  logic [1:0]       state_r, state_nxt;
  logic [CNT_W-1:0] sidx_r, sidx_nxt;
  logic [WID_W-1:0] col_r, col_nxt;
  logic [CNT_W-1:0] npi_r, npi_nxt;
  logic             first_r, first_nxt;
  logic [COL_W-1:0] ncol_r, ncol_nxt;
  logic [COL_W:0]   rem_r, rem_nxt;
  logic [CNT_W-1:0] q_r, q_nxt;
  logic [4:0]       cnt_r, cnt_nxt;

  logic             accept, picked;
  logic [CNT_W-1:0] idx, e_npi;
  logic [WID_W-1:0] e_col, col_inc;
  logic             e_first;
  logic [SMP_W-1:0] v_clamp;
  logic [COL_W+CNT_W-1:0] prod;
  logic [COL_W+1:0] trial;

  assign in_if.ready = (state_r == F_IDLE) && !q_full;
  assign accept      = in_if.valid && in_if.ready;

  // classify the item against the current pick
  always_comb begin
    idx     = in_if.trace_start ? '0 : sidx_r;
    e_col   = in_if.trace_start ? '0 : col_r;
    e_npi   = in_if.trace_start ? '0 : npi_r;
    e_first = in_if.trace_start ? 1'b1 : first_r;
    col_inc = e_col + 1'b1;
    picked  = (cfg.full_scale != '0) && (e_col < cfg.width) && (idx == e_npi)
              && (e_npi < cfg.sample_count);
    v_clamp = (in_if.sample > cfg.full_scale) ? cfg.full_scale : in_if.sample;
    push    = accept && picked;
    push_data.diff   = cfg.full_scale - v_clamp;
    push_data.column = e_col[COL_W-1:0];
    push_data.first  = e_first;
  end

  // pick division: (col * sample_count) / width, one quotient bit a cycle
  always_comb begin
    prod  = ncol_r * cfg.sample_count;
    trial = {rem_r, q_r[CNT_W-1]};
  end

  always_comb begin
    state_nxt = state_r;
    sidx_nxt  = sidx_r;
    col_nxt   = col_r;
    npi_nxt   = npi_r;
    first_nxt = first_r;
    ncol_nxt  = ncol_r;
    rem_nxt   = rem_r;
    q_nxt     = q_r;
    cnt_nxt   = cnt_r;
    case (state_r)
      F_IDLE: begin
        if (accept) begin
          sidx_nxt  = (idx != {CNT_W{1'b1}}) ? idx + 1'b1 : idx;
          col_nxt   = e_col;
          npi_nxt   = e_npi;
          first_nxt = e_first;
          if (picked) begin
            first_nxt = 1'b0;
            col_nxt   = col_inc;
            if (col_inc < cfg.width) begin
              if (cfg.sample_count <= CNT_W'(cfg.width)) begin
                npi_nxt = CNT_W'(col_inc);
              end else begin
                ncol_nxt  = col_inc[COL_W-1:0];
                state_nxt = F_MUL;
              end
            end
          end
        end
      end
      F_MUL: begin
        rem_nxt   = {1'b0, prod[COL_W+CNT_W-1:CNT_W]};
        q_nxt     = prod[CNT_W-1:0];
        cnt_nxt   = 5'(CNT_W);
        state_nxt = F_DIV;
      end
      F_DIV: begin
        if (trial >= (COL_W+2)'(cfg.width)) begin
          rem_nxt = (COL_W+1)'(trial - (COL_W+2)'(cfg.width));
          q_nxt   = {q_r[CNT_W-2:0], 1'b1};
        end else begin
          rem_nxt = trial[COL_W:0];
          q_nxt   = {q_r[CNT_W-2:0], 1'b0};
        end
        cnt_nxt = cnt_r - 1'b1;
        if (cnt_r == 5'd1) begin
          npi_nxt   = q_nxt;
          state_nxt = F_IDLE;
        end
      end
      default: state_nxt = F_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
      sidx_r  <= '0;
      col_r   <= '0;
      npi_r   <= '0;
      first_r <= 1'b1;
    end else begin
      state_r <= state_nxt;
      sidx_r  <= sidx_nxt;
      col_r   <= col_nxt;
      npi_r   <= npi_nxt;
      first_r <= first_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ncol_r <= ncol_nxt;
    rem_r  <= rem_nxt;
    q_r    <= q_nxt;
    cnt_r  <= cnt_nxt;
  end
endmodule

// ----- sv/wtr_back.sv -----
module wtr_back (
  input  logic            clk,
  input  logic            rst_n,
  input  wtr_pkg::cfg_t   cfg,
  input  wtr_pkg::point_t pop_data,
  input  logic            q_empty,
  output logic            pop,
  wtr_out_if.source       out_if
);
  import wtr_pkg::*;

  localparam logic [2:0] B_IDLE = 3'd0;
  localparam logic [2:0] B_MUL  = 3'd1;
  localparam logic [2:0] B_DIV  = 3'd2;
  localparam logic [2:0] B_OUT0 = 3'd3;
  localparam logic [2:0] B_OUT1 = 3'd4;

  logic [2:0]       state_r, state_nxt;
  point_t           pt_r, pt_nxt;
  logic [SMP_W-1:0] rem_r, rem_nxt;
  logic [ROW_W-1:0] q_r, q_nxt;
  logic [3:0]       cnt_r, cnt_nxt;
  logic [ROW_W-1:0] prev_r, prev_nxt;

  logic             ov_r, ov_nxt;
  logic [COL_W-1:0] o_col_r, o_col_nxt;
  logic [ROW_W-1:0] o_top_r, o_top_nxt, o_bot_r, o_bot_nxt;
  logic             o_last_r, o_last_nxt;

  logic [SMP_W+ROW_W-1:0] prod;
  logic [SMP_W:0]   trial;
  logic             can_load, up;
  logic [ROW_W-1:0] y, y2, d, h2, mid0, mid1, lo0, hi0, lo1, hi1;

  assign can_load = !ov_r || out_if.ready;
  assign pop      = (state_r == B_IDLE) && !q_empty;

  assign out_if.valid        = ov_r;
  assign out_if.column       = o_col_r;
  assign out_if.span_top     = o_top_r;
  assign out_if.span_bottom  = o_bot_r;
  assign out_if.pixel_color  = cfg.color;
  assign out_if.last_of_item = o_last_r;

  // row division: diff * (height-1) / full_scale, one quotient bit a cycle
  always_comb begin
    prod  = pt_r.diff * cfg.height_m1;
    trial = {rem_r, q_r[ROW_W-1]};
  end

  // line spans between previous row and new row, one column apart
  always_comb begin
    y    = prev_r;
    y2   = q_r;
    up   = y < y2;
    d    = up ? y2 - y : y - y2;
    h2   = d >> 1;
    mid0 = up ? y + h2 : y - h2;
    mid1 = (d == '0) ? y2 : (up ? y + h2 + 1'b1 : y - h2 - 1'b1);
    lo0  = up ? y : mid0;
    hi0  = up ? mid0 : y;
    lo1  = up ? mid1 : y2;
    hi1  = up ? y2 : mid1;
  end

  always_comb begin
    state_nxt  = state_r;
    pt_nxt     = pt_r;
    rem_nxt    = rem_r;
    q_nxt      = q_r;
    cnt_nxt    = cnt_r;
    prev_nxt   = prev_r;
    ov_nxt     = ov_r && !out_if.ready;
    o_col_nxt  = o_col_r;
    o_top_nxt  = o_top_r;
    o_bot_nxt  = o_bot_r;
    o_last_nxt = o_last_r;
    case (state_r)
      B_IDLE: begin
        if (pop) begin
          pt_nxt    = pop_data;
          state_nxt = B_MUL;
        end
      end
      B_MUL: begin
        rem_nxt   = prod[SMP_W+ROW_W-1:ROW_W];
        q_nxt     = prod[ROW_W-1:0];
        cnt_nxt   = 4'(ROW_W);
        state_nxt = B_DIV;
      end
      B_DIV: begin
        if (trial >= {1'b0, cfg.full_scale}) begin
          rem_nxt = SMP_W'(trial - {1'b0, cfg.full_scale});
          q_nxt   = {q_r[ROW_W-2:0], 1'b1};
        end else begin
          rem_nxt = trial[SMP_W-1:0];
          q_nxt   = {q_r[ROW_W-2:0], 1'b0};
        end
        cnt_nxt = cnt_r - 1'b1;
        if (cnt_r == 4'd1) state_nxt = B_OUT0;
      end
      B_OUT0: begin
        if (can_load) begin
          ov_nxt = 1'b1;
          if (pt_r.first) begin
            o_col_nxt  = pt_r.column;
            o_top_nxt  = q_r;
            o_bot_nxt  = q_r;
            o_last_nxt = 1'b1;
            prev_nxt   = q_r;
            state_nxt  = B_IDLE;
          end else begin
            o_col_nxt  = pt_r.column - 1'b1;
            o_top_nxt  = lo0;
            o_bot_nxt  = hi0;
            o_last_nxt = 1'b0;
            state_nxt  = B_OUT1;
          end
        end
      end
      B_OUT1: begin
        if (can_load) begin
          ov_nxt     = 1'b1;
          o_col_nxt  = pt_r.column;
          o_top_nxt  = lo1;
          o_bot_nxt  = hi1;
          o_last_nxt = 1'b1;
          prev_nxt   = q_r;
          state_nxt  = B_IDLE;
        end
      end
      default: state_nxt = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= B_IDLE;
      ov_r    <= 1'b0;
      prev_r  <= '0;
    end else begin
      state_r <= state_nxt;
      ov_r    <= ov_nxt;
      prev_r  <= prev_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pt_r     <= pt_nxt;
    rem_r    <= rem_nxt;
    q_r      <= q_nxt;
    cnt_r    <= cnt_nxt;
    o_col_r  <= o_col_nxt;
    o_top_r  <= o_top_nxt;
    o_bot_r  <= o_bot_nxt;
    o_last_r <= o_last_nxt;
  end
endmodule

// ----- sv/waveform_trace_rasterizer_top.sv -----
// channel   dir  handshake            payload
// in_if     in   valid/ready          sample, trace_start
// out_if    out  valid/ready          column, span_top, span_bottom, pixel_color, last_of_item
// cfg_*     in   cfg_we (no stall)    cfg_index, cfg_data
//
// An unpicked item is handled in F_IDLE alone. A picked item also needs a multiply and a
// 16-step pick division when sample_count exceeds the width; in_if is not ready meanwhile.
// The back pops a point and runs the row division (1 multiply, 8 steps),
// then emits its spans, one for the first point of a trace and two otherwise.
// A 2-entry queue parts front and back; out_if is registered; a stall holds back and front.
// Synchronous active-low reset; no clearing pass.
module waveform_trace_rasterizer_top (
  input  logic                               clk,
  input  logic                               rst_n,
  wtr_in_if.sink                             in_if,
  wtr_out_if.source                          out_if,
  input  logic                               cfg_we,
  input  logic [wtr_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [wtr_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import wtr_pkg::*;

  logic [SMP_W-1:0]    full_scale_r;
  logic [CNT_W-1:0]    sample_count_r;
  logic [PW_REG_W-1:0] plot_width_r;
  logic [PH_REG_W-1:0] plot_height_r;
  logic [CLR_W-1:0]    trace_color_r;

  cfg_t   cfg;
  point_t push_data, pop_data;
  logic   push, pop, q_full, q_empty;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      full_scale_r   <= SMP_W'(4095);
      sample_count_r <= CNT_W'(1024);
      plot_width_r   <= PW_REG_W'(512);
      plot_height_r  <= PH_REG_W'(256);
      trace_color_r  <= 32'hFF00FF00;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_FULL_SCALE:   full_scale_r   <= cfg_data[SMP_W-1:0];
        REG_SAMPLE_COUNT: sample_count_r <= cfg_data[CNT_W-1:0];
        REG_PLOT_WIDTH:   plot_width_r   <= cfg_data[PW_REG_W-1:0];
        REG_PLOT_HEIGHT:  plot_height_r  <= cfg_data[PH_REG_W-1:0];
        REG_TRACE_COLOR:  trace_color_r  <= cfg_data[CLR_W-1:0];
        default: ;
      endcase
    end
  end

  // clamped width and height
  always_comb begin
    cfg.full_scale   = full_scale_r;
    cfg.sample_count = sample_count_r;
    cfg.color        = trace_color_r;
    if (plot_width_r > PW_REG_W'(MAX_WIDTH)) cfg.width = WID_W'(MAX_WIDTH);
    else                                     cfg.width = WID_W'(plot_width_r);
    if (plot_height_r == '0)                         cfg.height_m1 = '0;
    else if (plot_height_r > PH_REG_W'(MAX_HEIGHT))  cfg.height_m1 = ROW_W'(MAX_HEIGHT - 1);
    else                                             cfg.height_m1 = ROW_W'(plot_height_r - 1'b1);
  end

  wtr_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .in_if     (in_if),
    .push      (push),
    .push_data (push_data),
    .q_full    (q_full)
  );

  wtr_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .full      (q_full),
    .pop       (pop),
    .pop_data  (pop_data),
    .empty     (q_empty)
  );

  wtr_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg),
    .pop_data (pop_data),
    .q_empty  (q_empty),
    .pop      (pop),
    .out_if   (out_if)
  );
endmodule
